>>> rtl/core/ncdf_pkg.sv
package ncdf_pkg;

  // field widths of the channels
  localparam int ARG_W = 16;
  localparam int CDF_W = 17;
  localparam int FRAC_BITS_OUT_DEF = 16;

  // q30 constants, rounded half up from nine decimal places
  localparam logic [63:0] QDEN = 64'd1000000000;
  localparam logic [63:0] QRND = 64'd500000000;

  localparam logic [29:0] INV_SQRT2 = 30'(((64'd707106781 << 30) + QRND) / QDEN);
  localparam logic [28:0] COEF_P    = 29'(((64'd327591100 << 30) + QRND) / QDEN);
  localparam logic [29:0] LN_TWO    = 30'(((64'd693147181 << 30) + QRND) / QDEN);

  localparam logic [32:0] A1_MAG = 33'(((64'd254829592 << 30) + QRND) / QDEN);
  localparam logic [32:0] A2_MAG = 33'(((64'd284496736 << 30) + QRND) / QDEN);
  localparam logic [32:0] A3_MAG = 33'(((64'd1421413741 << 30) + QRND) / QDEN);
  localparam logic [32:0] A4_MAG = 33'(((64'd1453152027 << 30) + QRND) / QDEN);
  localparam logic [32:0] A5_MAG = 33'(((64'd1061405429 << 30) + QRND) / QDEN);

  localparam logic signed [32:0] COEF_A1 = $signed(A1_MAG);
  localparam logic signed [32:0] COEF_A2 = -$signed(A2_MAG);
  localparam logic signed [32:0] COEF_A3 = $signed(A3_MAG);
  localparam logic signed [32:0] COEF_A4 = -$signed(A4_MAG);
  localparam logic signed [32:0] COEF_A5 = $signed(A5_MAG);

  // fixed point helpers
  localparam logic [31:0] QONE     = 32'd1 << 30;
  localparam logic [30:0] QONE31   = 31'd1 << 30;
  localparam logic [63:0] QHALF64  = 64'd1 << 29;
  localparam logic [31:0] REM_INIT = 32'd1 << 29;

  // exponential series shape
  localparam int KSTEPS   = 7;
  localparam int TERMS    = 13;
  localparam int RCP_W    = 31;
  localparam int EXP_KMAX = 40;

  // one item as it travels down the pipeline
  typedef struct packed {
    logic               neg;
    logic [15:0]        mag;
    logic [45:0]        zp;
    logic [32:0]        z;
    logic [61:0]        pz;
    logic [61:0]        sq;
    logic [31:0]        den;
    logic [31:0]        rem;
    logic [30:0]        nlo;
    logic [30:0]        t;
    logic [35:0]        w;
    logic [6:0]         k;
    logic               hneg;
    logic [62:0]        prod;
    logic signed [32:0] h;
    logic [62:0]        q;
    logic signed [32:0] sum;
    logic [31:0]        sc;
    logic [30:0]        e;
    logic [31:0]        r31;
    logic [16:0]        cdf;
  } item_t;

  // coefficient added after each horner multiply, zero after the last one
  function automatic logic signed [32:0] coef_add(input int j);
    logic signed [32:0] c;
    case (j)
      0: c = COEF_A4;
      1: c = COEF_A3;
      2: c = COEF_A2;
      3: c = COEF_A1;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/core/ncdf_arg_if.sv
interface ncdf_arg_if;
  logic                               valid;
  logic                               ready;
  logic signed [ncdf_pkg::ARG_W-1:0]  arg_value;

  modport source (output valid, output arg_value, input ready);
  modport sink (input valid, input arg_value, output ready);
endinterface

>>> rtl/core/ncdf_cdf_if.sv
interface ncdf_cdf_if;
  logic                        valid;
  logic                        ready;
  logic [ncdf_pkg::CDF_W-1:0]  cdf_value;

  modport source (output valid, output cdf_value, input ready);
  modport sink (input valid, input cdf_value, output ready);
endinterface

>>> rtl/core/ncdf_front.sv
module ncdf_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [ncdf_pkg::ARG_W-1:0] arg_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output ncdf_pkg::item_t                   out_item
);
  import ncdf_pkg::*;

  localparam int NST = 5;

  item_t          seed;
  item_t          stg [1:NST];
  logic [NST:1]   vld;
  logic [NST+1:1] take;

  // magnitude and sign of the argument
  always_comb begin
    seed = '0;
    seed.neg = arg_value[ARG_W-1];
    seed.mag = arg_value[ARG_W-1] ? 16'(17'h10000 - {1'b0, arg_value}) : arg_value;
  end

  assign take[NST+1] = out_ready;
  assign in_ready    = take[1];
  assign out_valid   = vld[NST];
  assign out_item    = stg[NST];

  for (genvar i = 1; i <= NST; i++) begin : g_st
    item_t p;
    item_t d;
    item_t s_q;
    logic  vin;
    logic  v_q;

    if (i == 1) begin : g_head
      assign p   = seed;
      assign vin = in_valid;
    end else begin : g_body
      assign p   = stg[i-1];
      assign vin = vld[i-1];
    end

    assign take[i] = !v_q || take[i+1];
    assign vld[i]  = v_q;
    assign stg[i]  = s_q;

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q <= 1'b0;
      end else if (take[i]) begin
        v_q <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (take[i] && vin) begin
        s_q <= d;
      end
    end

    if (i == 1) begin : g_scale
      // |x| times 1/sqrt(2)
      always_comb begin
        d = p;
        d.zp = 46'(p.mag) * 46'(INV_SQRT2);
      end
    end else if (i == 2) begin : g_z
      logic [46:0] zs;
      assign zs = {1'b0, p.zp} + 47'd2048;
      always_comb begin
        d = p;
        d.z = zs[44:12];
      end
    end else if (i == 3) begin : g_pz
      // p times z for the denominator
      always_comb begin
        d = p;
        d.pz = 62'(p.z) * 62'(COEF_P);
      end
    end else if (i == 4) begin : g_den
      logic [62:0] ps;
      assign ps = {1'b0, p.pz} + (63'd1 << 29);
      // denominator and z squared from the q28 copy of z
      always_comb begin
        d = p;
        d.den = QONE + ps[61:30];
        d.sq  = 62'(p.z[32:2]) * 62'(p.z[32:2]);
      end
    end else begin : g_w
      logic [62:0] ss;
      assign ss = {1'b0, p.sq} + (63'd1 << 25);
      // exponent argument and divider start values
      always_comb begin
        d = p;
        d.w   = ss[61:26];
        d.rem = REM_INIT;
        d.nlo = p.den[31:1];
        d.t   = '0;
        d.k   = '0;
      end
    end
  end

endmodule

>>> rtl/core/ncdf_recip.sv
module ncdf_recip (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  ncdf_pkg::item_t in_item,
  output logic            out_valid,
  input  logic            out_ready,
  output ncdf_pkg::item_t out_item
);
  import ncdf_pkg::*;

  // one quotient bit of t = round(2^60 / den) per stage
  localparam int NST = RCP_W;

  item_t          stg [1:NST];
  logic [NST:1]   vld;
  logic [NST+1:1] take;

  assign take[NST+1] = out_ready;
  assign in_ready    = take[1];
  assign out_valid   = vld[NST];
  assign out_item    = stg[NST];

  for (genvar i = 1; i <= NST; i++) begin : g_st
    item_t       p;
    item_t       d;
    item_t       s_q;
    logic        vin;
    logic        v_q;
    logic [32:0] trial;
    logic        ge;

    if (i == 1) begin : g_head
      assign p   = in_item;
      assign vin = in_valid;
    end else begin : g_body
      assign p   = stg[i-1];
      assign vin = vld[i-1];
    end

    assign take[i] = !v_q || take[i+1];
    assign vld[i]  = v_q;
    assign stg[i]  = s_q;

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q <= 1'b0;
      end else if (take[i]) begin
        v_q <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (take[i] && vin) begin
        s_q <= d;
      end
    end

    // restoring step: bring in the next dividend bit, subtract if it fits
    assign trial = {p.rem, p.nlo[30]};
    assign ge    = trial >= {1'b0, p.den};

    always_comb begin
      d = p;
      d.nlo = {p.nlo[29:0], 1'b0};
      d.t   = {p.t[29:0], ge};
      d.rem = ge ? 32'(trial - {1'b0, p.den}) : trial[31:0];
    end
  end

endmodule

>>> rtl/core/ncdf_horner.sv
module ncdf_horner (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  ncdf_pkg::item_t in_item,
  output logic            out_valid,
  input  logic            out_ready,
  output ncdf_pkg::item_t out_item
);
  import ncdf_pkg::*;

  // five multiply stages, each followed by a round and add stage
  localparam int NST = 10;

  item_t          stg [1:NST];
  logic [NST:1]   vld;
  logic [NST+1:1] take;

  assign take[NST+1] = out_ready;
  assign in_ready    = take[1];
  assign out_valid   = vld[NST];
  assign out_item    = stg[NST];

  for (genvar i = 1; i <= NST; i++) begin : g_st
    localparam int J = (i - 1) / 2;
    item_t p;
    item_t d;
    item_t s_q;
    logic  vin;
    logic  v_q;

    if (i == 1) begin : g_head
      assign p   = in_item;
      assign vin = in_valid;
    end else begin : g_body
      assign p   = stg[i-1];
      assign vin = vld[i-1];
    end

    assign take[i] = !v_q || take[i+1];
    assign vld[i]  = v_q;
    assign stg[i]  = s_q;

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q <= 1'b0;
      end else if (take[i]) begin
        v_q <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (take[i] && vin) begin
        s_q <= d;
      end
    end

    if (((i - 1) % 2) == 0) begin : g_mul
      logic signed [32:0] h;
      logic [31:0]        hm;
      // sign-magnitude product h * t
      assign h  = (J == 0) ? COEF_A5 : p.h;
      assign hm = h[32] ? 32'(-h) : 32'(h);
      always_comb begin
        d = p;
        d.hneg = h[32];
        d.prod = 63'(hm) * 63'(p.t);
      end
    end else begin : g_add
      localparam logic signed [32:0] CADD = coef_add(J);
      logic [63:0]        rs;
      logic [32:0]        m;
      logic signed [34:0] sm;
      // round half away from zero, restore sign, add next coefficient
      assign rs = 64'(p.prod) + QHALF64;
      assign m  = rs[62:30];
      assign sm = p.hneg ? -$signed({2'b0, m}) : $signed({2'b0, m});
      always_comb begin
        d = p;
        d.h = 33'(sm + 35'(CADD));
      end
    end
  end

endmodule

>>> rtl/core/ncdf_expo.sv
module ncdf_expo (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  ncdf_pkg::item_t in_item,
  output logic            out_valid,
  input  logic            out_ready,
  output ncdf_pkg::item_t out_item
);
  import ncdf_pkg::*;

  // k steps, two stages per series term, final sum, final shift
  localparam int NST = KSTEPS + 2 * TERMS + 2;
  localparam int SH_LAST = RCP_W + $clog2(TERMS);

  item_t          stg [1:NST];
  logic [NST:1]   vld;
  logic [NST+1:1] take;

  assign take[NST+1] = out_ready;
  assign in_ready    = take[1];
  assign out_valid   = vld[NST];
  assign out_item    = stg[NST];

  for (genvar i = 1; i <= NST; i++) begin : g_st
    item_t p;
    item_t d;
    item_t s_q;
    logic  vin;
    logic  v_q;

    if (i == 1) begin : g_head
      assign p   = in_item;
      assign vin = in_valid;
    end else begin : g_body
      assign p   = stg[i-1];
      assign vin = vld[i-1];
    end

    assign take[i] = !v_q || take[i+1];
    assign vld[i]  = v_q;
    assign stg[i]  = s_q;

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q <= 1'b0;
      end else if (take[i]) begin
        v_q <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (take[i] && vin) begin
        s_q <= d;
      end
    end

    if (i <= KSTEPS) begin : g_k
      // w = k * ln2 + r, one bit of k per stage, w keeps the remainder
      localparam int J = KSTEPS - i;
      localparam logic [36:0] LIM = 37'(LN_TWO) << J;
      logic ge;
      assign ge = {1'b0, p.w} >= LIM;
      always_comb begin
        d = p;
        d.k = {p.k[5:0], ge};
        if (ge) begin
          d.w = 36'({1'b0, p.w} - LIM);
        end
      end
    end else if (i <= KSTEPS + 2 * TERMS && ((i - KSTEPS - 1) % 2) == 0) begin : g_tmul
      // finish the previous term into the sum, then term * r
      localparam int N   = (i - KSTEPS - 1) / 2 + 1;
      localparam int NP  = (N > 1) ? N - 1 : 1;
      localparam int SHP = RCP_W + $clog2(NP);
      logic [30:0] tc;
      assign tc = (N == 1) ? QONE31 : 31'(p.q >> SHP);
      always_comb begin
        d = p;
        if (N == 1) begin
          d.sum = $signed({1'b0, QONE});
        end else if ((NP % 2) == 1) begin
          d.sum = p.sum - $signed({2'b0, tc});
        end else begin
          d.sum = p.sum + $signed({2'b0, tc});
        end
        d.prod = 63'(tc) * 63'(p.w[29:0]);
      end
    end else if (i <= KSTEPS + 2 * TERMS) begin : g_tdiv
      // round to q30, then divide by n through a reciprocal multiply
      localparam int N = (i - KSTEPS) / 2;
      localparam int L = $clog2(N);
      localparam logic [31:0] M =
        32'(((64'd1 << (RCP_W + L)) + 64'(N) - 64'd1) / 64'(N));
      localparam logic [30:0] HALF = 31'(N / 2);
      logic [63:0] rs;
      logic [30:0] v;
      assign rs = 64'(p.prod) + QHALF64;
      assign v  = rs[60:30] + HALF;
      always_comb begin
        d = p;
        d.q = 63'(v) * 63'(M);
      end
    end else if (i == KSTEPS + 2 * TERMS + 1) begin : g_sum
      logic [31:0]        tc;
      logic signed [32:0] s;
      // last odd term, clamp at zero
      assign tc = 32'(p.q >> SH_LAST);
      assign s  = p.sum - $signed({1'b0, tc});
      always_comb begin
        d = p;
        d.sum = s;
        d.sc  = s[32] ? '0 : s[31:0];
      end
    end else begin : g_shift
      logic [31:0] sh;
      // scale by 2^-k with rounding, tiny results go to zero
      assign sh = (p.sc >> (p.k - 7'd1)) + 32'd1;
      always_comb begin
        d = p;
        if (p.k >= 7'(EXP_KMAX)) begin
          d.e = '0;
        end else if (p.k == '0) begin
          d.e = 31'(p.sc);
        end else begin
          d.e = 31'(sh >> 1);
        end
      end
    end
  end

endmodule

>>> rtl/core/ncdf_out.sv
module ncdf_out #(
  parameter int FRAC_BITS_OUT = ncdf_pkg::FRAC_BITS_OUT_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  ncdf_pkg::item_t in_item,
  output logic            out_valid,
  input  logic            out_ready,
  output ncdf_pkg::item_t out_item
);
  import ncdf_pkg::*;

  localparam int NST = 3;
  localparam int RW  = (33 + FRAC_BITS_OUT > 48) ? 33 + FRAC_BITS_OUT : 48;

  item_t          stg [1:NST];
  logic [NST:1]   vld;
  logic [NST+1:1] take;

  assign take[NST+1] = out_ready;
  assign in_ready    = take[1];
  assign out_valid   = vld[NST];
  assign out_item    = stg[NST];

  for (genvar i = 1; i <= NST; i++) begin : g_st
    item_t p;
    item_t d;
    item_t s_q;
    logic  vin;
    logic  v_q;

    if (i == 1) begin : g_head
      assign p   = in_item;
      assign vin = in_valid;
    end else begin : g_body
      assign p   = stg[i-1];
      assign vin = vld[i-1];
    end

    assign take[i] = !v_q || take[i+1];
    assign vld[i]  = v_q;
    assign stg[i]  = s_q;

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q <= 1'b0;
      end else if (take[i]) begin
        v_q <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (take[i] && vin) begin
        s_q <= d;
      end
    end

    if (i == 1) begin : g_mul
      logic [31:0] pm;
      // poly times exp(-z*z), sign-magnitude
      assign pm = p.h[32] ? 32'(-p.h) : 32'(p.h);
      always_comb begin
        d = p;
        d.hneg = p.h[32];
        d.prod = 63'(pm) * 63'(p.e);
      end
    end else if (i == 2) begin : g_mirror
      logic [63:0]        rs;
      logic [32:0]        m;
      logic signed [35:0] sm;
      logic signed [35:0] y;
      logic signed [36:0] rr;
      // y = 1 - product, then 1 +/- y in q30 with clamp to 0..2
      assign rs = 64'(p.prod) + QHALF64;
      assign m  = rs[62:30];
      assign sm = p.hneg ? -$signed({3'b0, m}) : $signed({3'b0, m});
      assign y  = 36'sd1073741824 - sm;
      assign rr = p.neg ? (37'sd1073741824 - 37'(y)) : (37'sd1073741824 + 37'(y));
      always_comb begin
        d = p;
        if (rr < 0) begin
          d.r31 = '0;
        end else if (rr > 37'sd2147483648) begin
          d.r31 = 32'h8000_0000;
        end else begin
          d.r31 = rr[31:0];
        end
      end
    end else begin : g_round
      logic [RW-1:0] acc;
      // round half up to the output fraction, keep the field width
      assign acc = (RW'(p.r31) << FRAC_BITS_OUT) + (RW'(1) << 30);
      always_comb begin
        d = p;
        d.cdf = acc[31 +: CDF_W];
      end
    end
  end

endmodule

>>> rtl/core/normal_cdf_approx.sv
// channel | role   | payload                          | handshake
// arg     | sink   | arg_value, signed q4.12 x        | valid/ready
// cdf     | source | cdf_value, unsigned q1.16 phi(x) | valid/ready
//
// one item per cycle while cdf.ready is held high.
// depth is set by the 31-stage reciprocal divider and the 13-term exp series,
// two stages per term, each step one register stage.
// rst is synchronous and clears the stage valid bits; payload registers are not reset.
// a stage holds while its successor is full and bubbles close up, so arg.ready
// stays high under a cdf stall until every stage holds an item.
module normal_cdf_approx #(
  parameter int FRAC_BITS_OUT = ncdf_pkg::FRAC_BITS_OUT_DEF
) (
  input logic        clk,
  input logic        rst,
  ncdf_arg_if.sink   arg,
  ncdf_cdf_if.source cdf
);
  import ncdf_pkg::*;

  item_t fr_item;
  item_t rc_item;
  item_t hn_item;
  item_t ex_item;
  item_t ot_item;
  logic  fr_in_ready;
  logic  fr_valid;
  logic  fr_ready;
  logic  rc_valid;
  logic  rc_ready;
  logic  hn_valid;
  logic  hn_ready;
  logic  ex_valid;
  logic  ex_ready;

  // no item is taken while reset is held
  assign arg.ready = fr_in_ready && !rst;

  ncdf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (arg.valid),
    .in_ready  (fr_in_ready),
    .arg_value (arg.arg_value),
    .out_valid (fr_valid),
    .out_ready (fr_ready),
    .out_item  (fr_item)
  );

  ncdf_recip u_recip (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fr_valid),
    .in_ready  (fr_ready),
    .in_item   (fr_item),
    .out_valid (rc_valid),
    .out_ready (rc_ready),
    .out_item  (rc_item)
  );

  ncdf_horner u_horner (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rc_valid),
    .in_ready  (rc_ready),
    .in_item   (rc_item),
    .out_valid (hn_valid),
    .out_ready (hn_ready),
    .out_item  (hn_item)
  );

  ncdf_expo u_expo (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (hn_valid),
    .in_ready  (hn_ready),
    .in_item   (hn_item),
    .out_valid (ex_valid),
    .out_ready (ex_ready),
    .out_item  (ex_item)
  );

  ncdf_out #(
    .FRAC_BITS_OUT (FRAC_BITS_OUT)
  ) u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (ex_valid),
    .in_ready  (ex_ready),
    .in_item   (ex_item),
    .out_valid (cdf.valid),
    .out_ready (cdf.ready),
    .out_item  (ot_item)
  );

  assign cdf.cdf_value = ot_item.cdf;

endmodule

>>> rtl/core/ncdf_check.sv
module ncdf_check #(
  parameter int FRAC_BITS_OUT = ncdf_pkg::FRAC_BITS_OUT_DEF
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       arg_valid,
  input logic                       arg_ready,
  input logic                       cdf_valid,
  input logic                       cdf_ready,
  input logic [ncdf_pkg::CDF_W-1:0] cdf_value
);
  import ncdf_pkg::*;

  localparam logic [CDF_W-1:0] ONE_LIM =
    (FRAC_BITS_OUT > 16) ? '0 : CDF_W'(1 << FRAC_BITS_OUT);

  logic [7:0] inflight;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = arg_valid && arg_ready;
  assign out_acc = cdf_valid && cdf_ready;

  // items accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else if (in_acc && !out_acc) begin
      inflight <= inflight + 8'd1;
    end else if (!in_acc && out_acc) begin
      inflight <= inflight - 8'd1;
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !cdf_valid)
    else $error("cdf item shown right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    cdf_valid && !cdf_ready |=> cdf_valid && $stable(cdf_value))
    else $error("stalled cdf item changed");

  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    cdf_valid |-> inflight != 8'd0)
    else $error("cdf item without an accepted arg item");

  a_range: assert property (@(posedge clk) disable iff (rst)
    cdf_valid && (FRAC_BITS_OUT <= 16) |-> cdf_value <= ONE_LIM)
    else $error("cdf value above one");

endmodule

bind normal_cdf_approx ncdf_check #(
  .FRAC_BITS_OUT (FRAC_BITS_OUT)
) u_ncdf_check (
  .clk       (clk),
  .rst       (rst),
  .arg_valid (arg.valid),
  .arg_ready (arg.ready),
  .cdf_valid (cdf.valid),
  .cdf_ready (cdf.ready),
  .cdf_value (cdf.cdf_value)
);
